>>> src/nlp_pkg.sv
// shared types, codes and constants for the number literal parser
`default_nettype none
package nlp_pkg;

  localparam int unsigned DefValueWidth = 32;
  localparam int unsigned CharWidth     = 8;
  localparam int unsigned OutValueWidth = 32;
  localparam int unsigned StatusWidth   = 2;
  localparam int unsigned ModeWidth     = 3;
  localparam int unsigned OutDataWidth  = 48;

  // parse modes
  localparam logic [ModeWidth-1:0] MODE_IDLE      = 3'd0;
  localparam logic [ModeWidth-1:0] MODE_HEX_FIRST = 3'd1;
  localparam logic [ModeWidth-1:0] MODE_BIN_FIRST = 3'd2;
  localparam logic [ModeWidth-1:0] MODE_HEX       = 3'd3;
  localparam logic [ModeWidth-1:0] MODE_BIN       = 3'd4;
  localparam logic [ModeWidth-1:0] MODE_DEC       = 3'd5;

  // result status codes
  localparam logic [StatusWidth-1:0] ST_OK        = 2'd0;
  localparam logic [StatusWidth-1:0] ST_BAD_START = 2'd1;
  localparam logic [StatusWidth-1:0] ST_BAD_HEX   = 2'd2;
  localparam logic [StatusWidth-1:0] ST_BAD_BIN   = 2'd3;

  // characters
  localparam logic [CharWidth-1:0] CH_DOLLAR  = 8'h24;
  localparam logic [CharWidth-1:0] CH_PERCENT = 8'h25;
  localparam logic [CharWidth-1:0] CH_ZERO    = 8'h30;
  localparam logic [CharWidth-1:0] CH_ONE     = 8'h31;
  localparam logic [CharWidth-1:0] CH_NINE    = 8'h39;
  localparam logic [CharWidth-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CharWidth-1:0] CH_UPPER_F = 8'h46;
  localparam logic [CharWidth-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CharWidth-1:0] CH_LOWER_F = 8'h66;
  localparam logic [3:0]           DIGIT_TEN  = 4'hA;

  typedef struct packed {
    logic       is_dec;
    logic       is_hex;
    logic       is_bin;
    logic [3:0] value;
  } digit_info_t;

  typedef struct packed {
    logic [CharWidth-1:0]     stop_char;
    logic [StatusWidth-1:0]   status;
    logic [OutValueWidth-1:0] value;
  } result_t;

endpackage
`default_nettype wire

>>> src/nlp_digit_decode.sv
// classifies one character as a decimal, hex or binary digit and gives its value
`default_nettype none
module nlp_digit_decode (
  input  wire logic [nlp_pkg::CharWidth-1:0] char_code,
  output nlp_pkg::digit_info_t               info
);
  import nlp_pkg::*;

  logic is_num;
  logic is_low;
  logic is_up;

  always_comb begin
    is_num = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    is_low = (char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_F);
    is_up  = (char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_F);
    info.is_dec = is_num;
    info.is_hex = is_num || is_low || is_up;
    info.is_bin = (char_code == CH_ZERO) || (char_code == CH_ONE);
    if (is_low) begin
      info.value = 4'(char_code - CH_LOWER_A) + DIGIT_TEN;
    end else if (is_up) begin
      info.value = 4'(char_code - CH_UPPER_A) + DIGIT_TEN;
    end else begin
      info.value = 4'(char_code - CH_ZERO);
    end
  end

endmodule
`default_nettype wire

>>> src/nlp_core.sv
// parse state and accumulator with the per-character update
`default_nettype none
module nlp_core #(
  parameter int unsigned VALUE_WIDTH = nlp_pkg::DefValueWidth
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step_en,
  input  wire logic [nlp_pkg::CharWidth-1:0] char_code,
  output logic                               emit,
  output nlp_pkg::result_t                   res
);
  import nlp_pkg::*;

  logic [ModeWidth-1:0]   mode_r;
  logic [ModeWidth-1:0]   mode_nxt;
  logic [VALUE_WIDTH-1:0] acc_r;
  logic [VALUE_WIDTH-1:0] acc_nxt;
  logic [VALUE_WIDTH-1:0] dig_w;
  logic [63:0]            acc_ext;
  digit_info_t            dig;

  nlp_digit_decode u_dec (
    .char_code (char_code),
    .info      (dig)
  );

  assign dig_w   = VALUE_WIDTH'(dig.value);
  assign acc_ext = 64'(acc_r);

  always_comb begin
    mode_nxt      = mode_r;
    acc_nxt       = acc_r;
    emit          = 1'b0;
    res.value     = acc_ext[OutValueWidth-1:0];
    res.status    = ST_OK;
    res.stop_char = char_code;
    unique case (mode_r)
      MODE_HEX_FIRST: begin
        if (dig.is_hex) begin
          acc_nxt  = dig_w;
          mode_nxt = MODE_HEX;
        end else begin
          emit       = 1'b1;
          res.value  = '0;
          res.status = ST_BAD_HEX;
        end
      end
      MODE_BIN_FIRST: begin
        if (dig.is_bin) begin
          acc_nxt  = dig_w;
          mode_nxt = MODE_BIN;
        end else begin
          emit       = 1'b1;
          res.value  = '0;
          res.status = ST_BAD_BIN;
        end
      end
      MODE_HEX: begin
        if (dig.is_hex) acc_nxt = (acc_r << 4) | dig_w;
        else emit = 1'b1;
      end
      MODE_BIN: begin
        if (dig.is_bin) acc_nxt = (acc_r << 1) | dig_w;
        else emit = 1'b1;
      end
      MODE_DEC: begin
        // times ten as two shifted adds
        if (dig.is_dec) acc_nxt = (acc_r << 3) + (acc_r << 1) + dig_w;
        else emit = 1'b1;
      end
      default: begin
        if (char_code == CH_DOLLAR) begin
          mode_nxt = MODE_HEX_FIRST;
          acc_nxt  = '0;
        end else if (char_code == CH_PERCENT) begin
          mode_nxt = MODE_BIN_FIRST;
          acc_nxt  = '0;
        end else if (dig.is_dec) begin
          mode_nxt = MODE_DEC;
          acc_nxt  = dig_w;
        end else begin
          emit       = 1'b1;
          res.value  = '0;
          res.status = ST_BAD_START;
        end
      end
    endcase
    if (emit) begin
      mode_nxt = MODE_IDLE;
      acc_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= '0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/number_literal_parser_unit.sv
// top level: input register, parse step and result register
// each character is registered in the input register, and the result of a literal in the result register
// throughput: one character per cycle; a held result stalls only characters that end a literal
// the parse step is one shift-add on the accumulator between the two registers
// reset (synchronous, rst_n low) empties both registers and returns the parser to idle
`default_nettype none
module number_literal_parser_unit #(
  parameter int unsigned VALUE_WIDTH = nlp_pkg::DefValueWidth
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [nlp_pkg::CharWidth-1:0]    in_tdata,   // [7:0] char_code
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [nlp_pkg::OutDataWidth-1:0]      out_tdata   // [31:0] value, [33:32] status,
                                                            // [41:34] stop_char, rest zero
);
  import nlp_pkg::*;

  logic                 in_valid_r;
  logic [CharWidth-1:0] char_r;
  logic                 out_valid_r;
  result_t              res_r;
  result_t              res;
  logic                 emit;
  logic                 out_free;
  logic                 step_en;

  assign out_free  = !out_valid_r || out_tready;
  // a character that produces no result always moves on
  assign step_en   = in_valid_r && (!emit || out_free);
  assign in_tready = !in_valid_r || step_en;

  nlp_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .char_code (char_r),
    .emit      (emit),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) char_r <= in_tdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step_en && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && emit) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OutDataWidth'(res_r);

endmodule
`default_nettype wire
